@@ hdl/timed_event_scheduler_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the timed event scheduler
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_SCHEDULER_DEFINES_SVH
`define TIMED_EVENT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tes_pkg.sv @@
// ---------------------------------------------------------------------------
// tes_pkg
// Shared types and constants of the timed event scheduler.
// ---------------------------------------------------------------------------
package tes_pkg;

  // Field widths
  localparam int TIME_W = 24;
  localparam int KIND_W = 8;
  localparam int ADV_W  = 10;
  localparam int DAY_W  = 14;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;

  // Queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS);

  // Calendar constants
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;
  localparam int MIN_PER_DAY  = MIN_PER_HOUR * HOUR_PER_DAY;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Calendar reading at a saturated clock
  localparam int SAT_DAY  = TIME_MAX / MIN_PER_DAY + 1;
  localparam int SAT_HOUR = (TIME_MAX % MIN_PER_DAY) / MIN_PER_HOUR;
  localparam int SAT_MIN  = TIME_MAX % MIN_PER_HOUR;

  // Reset reading: day 1, 08:00
  localparam int RST_DAY  = 1;
  localparam int RST_HOUR = 8;
  localparam int RST_MIN  = 0;
  localparam int RST_ABS  = RST_HOUR * MIN_PER_HOUR + RST_MIN;

  // x / 60 as (x * 1093) >> 16, exact for x below 1083
  localparam int RECIP_60    = 1093;
  localparam int RECIP_SHIFT = 16;

  typedef enum logic [1:0] {
    STS_INSERTED = 2'd0,
    STS_REJECTED = 2'd1,
    STS_FIRED    = 2'd2,
    STS_NONE_DUE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_ADV_SUM,
    S_ADV_SPLIT,
    S_FIRE
  } state_e;

  typedef struct packed {
    logic                     op;
    logic [TIME_W-1:0]        event_time;
    logic signed [KIND_W-1:0] event_kind;
    logic [ADV_W-1:0]         advance_minutes;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic [TIME_W-1:0]        fired_time;
    logic signed [KIND_W-1:0] fired_kind;
    logic [DAY_W-1:0]         day_now;
    logic [HOUR_W-1:0]        hour_now;
    logic [MIN_W-1:0]         minute_now;
    logic                     last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    push;
    logic    pop;
    logic    clk_sum;
    logic    clk_split;
    logic    load_out;
    status_e out_status;
    logic    out_last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_op;
    logic out_free;
    logic q_full;
    logic head_due;
    logic next_due;
  } ctrl_sts_t;

endpackage

@@ hdl/tes_queue.sv @@
// ---------------------------------------------------------------------------
// tes_queue
// Sorted event queue: a row of cells ordered by due time, with a parallel
// position compare on insert and a one-cell shift on pop.
// ---------------------------------------------------------------------------
`include "timed_event_scheduler_defines.svh"

module tes_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [tes_pkg::TIME_W-1:0]       push_time_i,
  input  logic signed [tes_pkg::KIND_W-1:0] push_kind_i,
  input  logic                             pop_i,
  input  logic [tes_pkg::TIME_W-1:0]       now_i,
  output logic                             full_o,
  output logic                             head_due_o,
  output logic                             next_due_o,
  output logic [tes_pkg::TIME_W-1:0]       head_time_o,
  output logic signed [tes_pkg::KIND_W-1:0] head_kind_o
);
  import tes_pkg::*;

  logic [TIME_W-1:0]        time_q [QUEUE_DEPTH];
  logic signed [KIND_W-1:0] kind_q [QUEUE_DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;
  logic [QUEUE_DEPTH-1:0]   le;

  // Flag live cells due at or before the new event
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count_q) && (time_q[i] <= push_time_i);
    end
  end

  // Insert after all earlier-or-equal entries, or shift toward the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (push_i && !le[0]) begin
          time_q[0] <= push_time_i;
          kind_q[0] <= push_kind_i;
        end else if (pop_i) begin
          time_q[0] <= time_q[1];
          kind_q[0] <= kind_q[1];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (push_i && !le[i]) begin
          if (le[i-1]) begin
            time_q[i] <= push_time_i;
            kind_q[i] <= push_kind_i;
          end else begin
            time_q[i] <= time_q[i-1];
            kind_q[i] <= kind_q[i-1];
          end
        end else if (pop_i) begin
          if (i < QUEUE_DEPTH - 1) begin
            time_q[i] <= time_q[(i + 1) % QUEUE_DEPTH];
            kind_q[i] <= kind_q[(i + 1) % QUEUE_DEPTH];
          end
        end
      end
    end
  end

  // Track the fill level
  always_comb begin
    count_d = count_q;
    if (push_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign full_o      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_due_o  = (count_q != '0) && (time_q[0] <= now_i);
  assign next_due_o  = (count_q > CNT_W'(1)) && (time_q[1] <= now_i);
  assign head_time_o = time_q[0];
  assign head_kind_o = kind_q[0];

  `TES_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count out of range")
  `TES_ASSERT_IMP(a_head_sorted, clk_i, rst_ni, count_q > CNT_W'(1), time_q[0] <= time_q[1], "queue head out of order")
  `TES_ASSERT_NXT(a_pop_dec, clk_i, rst_ni, pop_i && !push_i, count_q == $past(count_q) - CNT_W'(1), "pop did not drop one entry")
  `TES_ASSERT_IMP(a_pop_due, clk_i, rst_ni, pop_i, head_due_o && !push_i, "pop of an entry not due")

endmodule

@@ hdl/tes_clock.sv @@
// ---------------------------------------------------------------------------
// tes_clock
// Absolute minute counter with day/hour/minute reading. An advance runs in
// two steps: add and saturate, then split the minute carry into hours.
// ---------------------------------------------------------------------------
module tes_clock (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sum_i,
  input  logic                        split_i,
  input  logic [tes_pkg::ADV_W-1:0]   minutes_i,
  output logic [tes_pkg::TIME_W-1:0]  abs_o,
  output logic [tes_pkg::DAY_W-1:0]   day_o,
  output logic [tes_pkg::HOUR_W-1:0]  hour_o,
  output logic [tes_pkg::MIN_W-1:0]   minute_o
);
  import tes_pkg::*;

  localparam int X_W    = ADV_W + 1;
  localparam int PROD_W = X_W + 11;
  localparam int Q_W    = PROD_W - RECIP_SHIFT;
  localparam int HS_W   = HOUR_W + 2;

  logic [TIME_W-1:0] abs_q;
  logic [DAY_W-1:0]  day_q;
  logic [HOUR_W-1:0] hour_q;
  logic [MIN_W-1:0]  min_q;
  logic              sat_q;
  logic [X_W-1:0]    x_q;
  logic [PROD_W-1:0] prod_q;

  logic [TIME_W:0]   sum;
  logic [X_W-1:0]    x;
  logic [Q_W-1:0]    q;
  logic [MIN_W-1:0]  rem;
  logic [HS_W-1:0]   hsum;

  // Add and saturate; start the minute split
  assign sum = {1'b0, abs_q} + (TIME_W + 1)'(minutes_i);
  assign x   = X_W'(min_q) + X_W'(minutes_i);

  // Quotient and remainder by sixty, then wrap hours into days
  assign q    = prod_q[PROD_W-1:RECIP_SHIFT];
  assign rem  = MIN_W'(x_q - X_W'(q) * X_W'(MIN_PER_HOUR));
  assign hsum = HS_W'(hour_q) + HS_W'(q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q  <= TIME_W'(RST_ABS);
      day_q  <= DAY_W'(RST_DAY);
      hour_q <= HOUR_W'(RST_HOUR);
      min_q  <= MIN_W'(RST_MIN);
      sat_q  <= 1'b0;
      x_q    <= '0;
      prod_q <= '0;
    end else begin
      if (sum_i) begin
        abs_q  <= sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        sat_q  <= sum[TIME_W];
        x_q    <= x;
        prod_q <= PROD_W'(x) * PROD_W'(RECIP_60);
      end
      if (split_i) begin
        if (sat_q) begin
          day_q  <= DAY_W'(SAT_DAY);
          hour_q <= HOUR_W'(SAT_HOUR);
          min_q  <= MIN_W'(SAT_MIN);
        end else begin
          min_q <= rem;
          if (hsum >= HS_W'(HOUR_PER_DAY)) begin
            hour_q <= HOUR_W'(hsum - HS_W'(HOUR_PER_DAY));
            day_q  <= day_q + DAY_W'(1);
          end else begin
            hour_q <= HOUR_W'(hsum);
          end
        end
      end
    end
  end

  assign abs_o    = abs_q;
  assign day_o    = day_q;
  assign hour_o   = hour_q;
  assign minute_o = min_q;

endmodule

@@ hdl/tes_ctrl.sv @@
// ---------------------------------------------------------------------------
// tes_ctrl
// Sequencer: takes one request, runs the insert or the clock advance, and
// drives one result per cycle while the output register has room.
// ---------------------------------------------------------------------------
module tes_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tes_pkg::ctrl_sts_t sts_i,
  output tes_pkg::ctrl_cmd_t cmd_o
);
  import tes_pkg::*;

  state_e                state_q, state_d;
  logic [FIRE_CNT_W-1:0] fire_cnt_q, fire_cnt_d;
  logic                  fire_last;

  // Stop after the budget of results or when the next entry is not due
  assign fire_last = (fire_cnt_q == FIRE_CNT_W'(MAX_RESULTS - 1)) || !sts_i.next_due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fire_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      fire_cnt_q <= fire_cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    fire_cnt_d = fire_cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_status = STS_INSERTED;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.in_op ? S_ADV_SUM : S_INS;
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.push       = !sts_i.q_full;
          cmd_o.out_status = sts_i.q_full ? STS_REJECTED : STS_INSERTED;
          state_d = S_IDLE;
        end
      end
      S_ADV_SUM: begin
        cmd_o.clk_sum = 1'b1;
        state_d = S_ADV_SPLIT;
      end
      S_ADV_SPLIT: begin
        cmd_o.clk_split = 1'b1;
        fire_cnt_d = '0;
        state_d = S_FIRE;
      end
      S_FIRE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.head_due) begin
            cmd_o.pop        = 1'b1;
            cmd_o.out_status = STS_FIRED;
            cmd_o.out_last   = fire_last;
            fire_cnt_d = fire_cnt_q + FIRE_CNT_W'(1);
            if (fire_last) begin
              state_d = S_IDLE;
            end
          end else begin
            cmd_o.out_status = STS_NONE_DUE;
            cmd_o.out_last   = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/timed_event_scheduler.sv @@
// ---------------------------------------------------------------------------
// timed_event_scheduler
// Time-ordered event queue driven by a day/hour/minute clock.
// ---------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i | request in
//  out     | out_valid_o, out_ready_i, out_data_o | result out
//
//  Insert: the request is captured in S_IDLE and the result loaded in S_INS.
//  Advance: add/saturate and divide-by-sixty steps of the clock unit, then
//  one fired event per cycle from the queue head while the output has room.
//  Reset: queue empty, clock at day 1, 08:00, no result pending.
//  A stalled output holds its register; the sequencer waits until it drains.
// ---------------------------------------------------------------------------
module timed_event_scheduler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tes_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tes_pkg::out_item_t out_data_o
);
  import tes_pkg::*;

  ctrl_cmd_t                cmd;
  ctrl_sts_t                sts;
  in_item_t                 item_q;
  out_item_t                out_q, out_d;
  logic                     out_valid_q;
  logic [TIME_W-1:0]        abs_now;
  logic [DAY_W-1:0]         day_now;
  logic [HOUR_W-1:0]        hour_now;
  logic [MIN_W-1:0]         minute_now;
  logic [TIME_W-1:0]        head_time;
  logic signed [KIND_W-1:0] head_kind;
  logic                     q_full, head_due, next_due;

  tes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tes_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd.push),
    .push_time_i (item_q.event_time),
    .push_kind_i (item_q.event_kind),
    .pop_i       (cmd.pop),
    .now_i       (abs_now),
    .full_o      (q_full),
    .head_due_o  (head_due),
    .next_due_o  (next_due),
    .head_time_o (head_time),
    .head_kind_o (head_kind)
  );

  tes_clock u_clock (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sum_i     (cmd.clk_sum),
    .split_i   (cmd.clk_split),
    .minutes_i (item_q.advance_minutes),
    .abs_o     (abs_now),
    .day_o     (day_now),
    .hour_o    (hour_now),
    .minute_o  (minute_now)
  );

  // Status back to the sequencer
  always_comb begin
    sts.in_op    = in_data_i.op;
    sts.out_free = !out_valid_q || out_ready_i;
    sts.q_full   = q_full;
    sts.head_due = head_due;
    sts.next_due = next_due;
  end

  // Hold the request
  always_ff @(posedge clk_i) begin
    if (cmd.capture) begin
      item_q <= in_data_i;
    end
  end

  // Build the result
  always_comb begin
    out_d.status     = cmd.out_status;
    out_d.fired_time = (cmd.out_status == STS_FIRED) ? head_time : '0;
    out_d.fired_kind = (cmd.out_status == STS_FIRED) ? head_kind : '0;
    out_d.day_now    = day_now;
    out_d.hour_now   = hour_now;
    out_d.minute_now = minute_now;
    out_d.last       = cmd.out_last;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/timed_event_scheduler_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// timed_event_scheduler_test
// Self-checking bench for the timed event scheduler. A behavioral copy of the
// sorted event queue and the day/hour/minute clock predicts every result of
// each accepted request. Directed tests cover reset, ordering and a full
// queue; random traffic runs under three idling mixes with an output hold-off.
// A final sweep runs long clock advances with far-future events left queued.
// ---------------------------------------------------------------------------
module timed_event_scheduler_test;
  import tes_pkg::*;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_TAIL     = 24;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 110;
  localparam int SWEEP_STEPS    = 24;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  timed_event_scheduler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the event queue and clock
  logic [TIME_W-1:0]        pend_time [$];
  logic signed [KIND_W-1:0] pend_kind [$];
  logic [TIME_W-1:0]        clock_abs;
  logic [DAY_W-1:0]         clock_day;
  logic [HOUR_W-1:0]        clock_hour;
  logic [MIN_W-1:0]         clock_min;

  out_item_t expected_results [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_output;
  int  mismatch_count;
  int  quiet_cycles;
  logic [TIME_W-1:0] recent_time;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Build one result at the current clock reading
  function automatic out_item_t clock_result(status_e sts, logic [TIME_W-1:0] t,
                                             logic signed [KIND_W-1:0] k, logic lst);
    out_item_t r;
    r.status     = sts;
    r.fired_time = t;
    r.fired_kind = k;
    r.day_now    = clock_day;
    r.hour_now   = clock_hour;
    r.minute_now = clock_min;
    r.last       = lst;
    return r;
  endfunction

  // Apply one request to the shadow state and queue its results
  function automatic void predict_request(in_item_t req);
    int          pos;
    int          fired;
    int unsigned sum;
    logic [TIME_W-1:0]        ft;
    logic signed [KIND_W-1:0] fk;
    logic                     lst;
    if (req.op == OP_INSERT) begin
      if (pend_time.size() >= QUEUE_DEPTH) begin
        expected_results.push_back(clock_result(STS_REJECTED, '0, '0, 1'b1));
      end else begin
        // Place after every entry due at or before it
        pos = 0;
        while (pos < pend_time.size() && pend_time[pos] <= req.event_time) pos++;
        pend_time.insert(pos, req.event_time);
        pend_kind.insert(pos, req.event_kind);
        expected_results.push_back(clock_result(STS_INSERTED, '0, '0, 1'b1));
      end
    end else begin
      // Advance and saturate the clock, then split it into day/hour/minute
      sum = 32'(clock_abs) + 32'(req.advance_minutes);
      if (sum > 32'(TIME_MAX)) sum = 32'(TIME_MAX);
      clock_abs  = TIME_W'(sum);
      clock_day  = DAY_W'(sum / MIN_PER_DAY + 1);
      clock_hour = HOUR_W'((sum % MIN_PER_DAY) / MIN_PER_HOUR);
      clock_min  = MIN_W'(sum % MIN_PER_HOUR);
      // Fire due events from the head, bounded per request
      fired = 0;
      while (fired < MAX_RESULTS && pend_time.size() > 0 && pend_time[0] <= clock_abs) begin
        ft = pend_time.pop_front();
        fk = pend_kind.pop_front();
        fired++;
        lst = (fired == MAX_RESULTS) || (pend_time.size() == 0) || (pend_time[0] > clock_abs);
        expected_results.push_back(clock_result(STS_FIRED, ft, fk, lst));
      end
      if (fired == 0) expected_results.push_back(clock_result(STS_NONE_DUE, '0, '0, 1'b1));
    end
  endfunction

  function automatic in_item_t make_insert(int unsigned t, logic signed [KIND_W-1:0] k);
    in_item_t r;
    if (t > 32'(TIME_MAX)) t = 32'(TIME_MAX);
    r.op              = OP_INSERT;
    r.event_time      = t[TIME_W-1:0];
    r.event_kind      = k;
    r.advance_minutes = ADV_W'($urandom_range(0, 1023));
    return r;
  endfunction

  function automatic in_item_t make_advance(int unsigned mins);
    in_item_t r;
    r.op              = OP_ADVANCE;
    r.event_time      = TIME_W'($urandom());
    r.event_kind      = KIND_W'($urandom());
    r.advance_minutes = mins[ADV_W-1:0];
    return r;
  endfunction

  function automatic string result_text(out_item_t r);
    return $sformatf("status=%0d time=%0d kind=%0d day=%0d %0d:%0d last=%0d",
                     r.status, r.fired_time, r.fired_kind, r.day_now, r.hour_now,
                     r.minute_now, r.last);
  endfunction

  function automatic void report_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch (%s) at %0t: expected %s / got %s", what, $realtime,
               result_text(want), result_text(got));
  endfunction

  // Offer one request, hold it until taken, then predict its results
  task automatic send_request(in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(req);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result against the oldest expectation; watch for a hang
  always @(posedge clk_i) begin : result_checker
    out_item_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("no result pending", '0, out_data_o);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.status !== want.status || out_data_o.fired_time !== want.fired_time ||
              out_data_o.fired_kind !== want.fired_kind || out_data_o.day_now !== want.day_now ||
              out_data_o.hour_now !== want.hour_now ||
              out_data_o.minute_now !== want.minute_now || out_data_o.last !== want.last)
            report_mismatch("field", want, out_data_o);
        end
      end
    end
  end

  // Reset reading, past events, equal due times and partial firing
  task automatic test_reset_and_order();
    send_request(make_advance(0));
    send_request(make_insert(0, -8'sd128));
    send_request(make_insert(480, 8'sd127));
    send_request(make_insert(500, 8'sd1));
    send_request(make_insert(500, 8'sd2));
    send_request(make_insert(502, -8'sd1));
    send_request(make_advance(20));
    send_request(make_advance(0));
    send_request(make_advance(1023));
    wait_drained();
  endtask

  // Fill the queue, reject one more, then fire all entries in one advance
  task automatic test_queue_full();
    int unsigned base;
    logic signed [KIND_W-1:0] k;
    base = clock_abs;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      k = (i == 0) ? -8'sd128 : (i == 1) ? 8'sd127 : 8'($urandom());
      send_request(make_insert(base + 7 * (QUEUE_DEPTH - 1 - i) / 2, k));
    end
    send_request(make_insert(0, 8'sd5));
    send_request(make_advance(1023));
    send_request(make_advance(0));
    wait_drained();
  endtask

  // Mostly near-term inserts and short advances, with some noise
  task automatic test_random_traffic(int n_items);
    int          roll;
    int unsigned t;
    int unsigned mins;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        roll = $urandom_range(99);
        if (roll < 12) t = recent_time;
        else if (roll < 22) t = clock_abs - $urandom_range(0, clock_abs < 600 ? clock_abs : 600);
        else if (roll < 30) t = clock_abs + $urandom_range(0, 4000);
        else t = clock_abs + $urandom_range(0, 600);
        recent_time = TIME_W'(t);
        send_request(make_insert(t, KIND_W'($urandom())));
      end else begin
        roll = $urandom_range(99);
        if (roll < 15) mins = 0;
        else if (roll < 30) mins = $urandom_range(0, 1023);
        else mins = $urandom_range(1, 150);
        send_request(make_advance(mins));
      end
    end
    wait_drained();
  endtask

  // Hold the output while requests keep coming so the input stalls
  task automatic test_output_holdoff();
    hold_output = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2) send_request(make_advance($urandom_range(0, 200)));
      else send_request(make_insert(clock_abs + $urandom_range(0, 300), KIND_W'($urandom())));
    end
    wait_drained();
  endtask

  // Run long advances with scattered inserts, some far in the future
  task automatic test_long_advances();
    for (int i = 0; i < SWEEP_STEPS; i++) begin
      if (i == 4) begin
        send_request(make_insert(TIME_MAX, 8'sd127));
        send_request(make_insert(TIME_MAX - 1, -8'sd128));
      end
      if (i % 8 == 0) send_request(make_insert($urandom() & TIME_MAX, KIND_W'($urandom())));
      send_request(make_advance(1023));
    end
    send_request(make_advance(0));
    send_request(make_advance(0));
    send_request(make_advance(1023));
    wait_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    hold_output    = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    clock_abs      = TIME_W'(RST_ABS);
    clock_day      = DAY_W'(RST_DAY);
    clock_hour     = HOUR_W'(RST_HOUR);
    clock_min      = MIN_W'(RST_MIN);
    recent_time    = TIME_W'(RST_ABS);
    send_idle_pct  = 10;
    recv_idle_pct  = 57;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_and_order();
    test_queue_full();
    test_random_traffic(RANDOM_ITEMS);
    test_output_holdoff();

    send_idle_pct = 57;
    recv_idle_pct = 10;
    test_random_traffic(RANDOM_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS);
    test_long_advances();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tes_pkg.sv
hdl/tes_queue.sv
hdl/tes_clock.sv
hdl/tes_ctrl.sv
hdl/timed_event_scheduler.sv
tb/timed_event_scheduler_test.sv
